// ===== hw/rtl/tccw_pkg.sv =====
// Shared types and constants for the text console character writer.
// No dependencies; used by all modules under hw/rtl.
`timescale 1ns / 1ps

package tccw_pkg;

  // Screen geometry and behavior constants
  localparam int WIDTH      = 80;
  localparam int HEIGHT     = 25;
  localparam int START_ROW  = 0;
  localparam int TAB_SPACES = 4;

  // Field widths fixed by the interface
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int POS_W   = 11;
  localparam int DATA_W  = 16;

  // Internal cell index width, wide enough for every cell of the screen
  localparam int CELLS   = WIDTH * HEIGHT;
  localparam int CELL_W  = $clog2(CELLS);
  localparam int TAB_W   = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;
  localparam int START_ROW_EFF = (START_ROW < HEIGHT) ? START_ROW : 0;

  // Command queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Command operations
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_PRINT = 3'd1;
  localparam logic [2:0] OP_BS    = 3'd2;
  localparam logic [2:0] OP_TAB   = 3'd3;
  localparam logic [2:0] OP_LF    = 3'd4;

  // Register indexes
  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  typedef struct packed {
    logic [2:0]        op;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

endpackage

// ===== hw/rtl/tccw_front.sv =====
// Front end: classifies incoming character bytes into commands.
// Depends on tccw_pkg; feeds tccw_queue.
`timescale 1ns / 1ps

module tccw_front (
  input  logic                          in_valid,
  input  logic [tccw_pkg::CHAR_W-1:0]   char_byte,
  input  logic                          q_full,
  output logic                          in_ready,
  output logic                          push,
  output tccw_pkg::cmd_t                cmd
);

  logic [2:0] op;

  always_comb begin
    case (char_byte)
      tccw_pkg::CH_NUL: op = tccw_pkg::OP_NONE;
      tccw_pkg::CH_BS:  op = tccw_pkg::OP_BS;
      tccw_pkg::CH_TAB: op = tccw_pkg::OP_TAB;
      tccw_pkg::CH_LF:  op = tccw_pkg::OP_LF;
      default:          op = tccw_pkg::OP_PRINT;
    endcase
  end

  assign in_ready = !q_full;
  // NUL is consumed here and never reaches the back end
  assign push     = in_valid && !q_full && (op != tccw_pkg::OP_NONE);
  assign cmd.op   = op;
  assign cmd.ch   = char_byte;

endmodule

// ===== hw/rtl/tccw_queue.sv =====
// Short command queue decoupling front and back ends.
// Depends on tccw_pkg.
`timescale 1ns / 1ps

module tccw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tccw_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output tccw_pkg::cmd_t  head_cmd
);

  tccw_pkg::cmd_t                  mem [tccw_pkg::QDEPTH];
  logic [tccw_pkg::QPTR_W-1:0]     wr_ptr;
  logic [tccw_pkg::QPTR_W-1:0]     rd_ptr;
  logic [tccw_pkg::QCNT_W-1:0]     count;

  localparam logic [tccw_pkg::QPTR_W-1:0] PTR_LAST = tccw_pkg::QPTR_W'(tccw_pkg::QDEPTH - 1);
  localparam logic [tccw_pkg::QCNT_W-1:0] CNT_FULL = tccw_pkg::QCNT_W'(tccw_pkg::QDEPTH);

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/tccw_back.sv =====
// Back end: cursor state, cell write generation and output register.
// Depends on tccw_pkg; takes commands from tccw_queue.
`timescale 1ns / 1ps

module tccw_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           head_valid,
  input  tccw_pkg::cmd_t                 head_cmd,
  input  logic [tccw_pkg::COLOR_W-1:0]   ink_color,
  input  logic [tccw_pkg::COLOR_W-1:0]   paper_color,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           cell_write,
  output logic [tccw_pkg::POS_W-1:0]     cell_address,
  output logic [tccw_pkg::DATA_W-1:0]    cell_data,
  output logic [tccw_pkg::POS_W-1:0]     cursor_position,
  output logic                           last
);

  localparam int CW = tccw_pkg::CELL_W;
  localparam logic [tccw_pkg::COL_W-1:0] LAST_COL = tccw_pkg::COL_W'(tccw_pkg::WIDTH - 1);
  localparam logic [tccw_pkg::ROW_W-1:0] LAST_ROW = tccw_pkg::ROW_W'(tccw_pkg::HEIGHT - 1);
  localparam logic [CW-1:0] LAST_POS  = CW'(tccw_pkg::CELLS - 1);
  localparam logic [CW-1:0] ROW_STEP  = CW'(tccw_pkg::WIDTH);
  localparam logic [CW-1:0] RESET_POS = CW'(tccw_pkg::START_ROW_EFF * tccw_pkg::WIDTH);
  localparam logic [tccw_pkg::ROW_W-1:0] RESET_ROW = tccw_pkg::ROW_W'(tccw_pkg::START_ROW_EFF);
  localparam logic [tccw_pkg::TAB_W-1:0] TAB_LAST = tccw_pkg::TAB_W'(tccw_pkg::TAB_SPACES - 1);

  // pos tracks row * WIDTH + col incrementally, so no multiplier is needed
  logic [tccw_pkg::COL_W-1:0] col, col_next;
  logic [tccw_pkg::ROW_W-1:0] row, row_next;
  logic [CW-1:0]              pos, pos_next;
  logic [tccw_pkg::TAB_W-1:0] tab_cnt;

  logic                          fire;
  logic                          emit;
  logic                          done;
  logic                          r_write;
  logic [CW-1:0]                 r_addr;
  logic [tccw_pkg::CHAR_W-1:0]   r_char;
  logic                          r_last;

  assign fire = head_valid && (!out_valid || out_ready);
  assign pop  = fire && done;

  always_comb begin
    col_next = col;
    row_next = row;
    pos_next = pos;
    emit     = 1'b0;
    done     = 1'b1;
    r_write  = 1'b0;
    r_addr   = '0;
    r_char   = '0;
    r_last   = 1'b1;
    case (head_cmd.op)
      tccw_pkg::OP_PRINT, tccw_pkg::OP_TAB: begin
        emit    = 1'b1;
        r_write = 1'b1;
        r_addr  = pos;
        r_char  = (head_cmd.op == tccw_pkg::OP_TAB) ? tccw_pkg::CH_SPACE : head_cmd.ch;
        r_last  = (head_cmd.op == tccw_pkg::OP_PRINT) || (tab_cnt == TAB_LAST);
        done    = r_last;
        if (col == LAST_COL) begin
          col_next = '0;
          row_next = (row == LAST_ROW) ? '0 : row + 1'b1;
        end else begin
          col_next = col + 1'b1;
        end
        pos_next = (pos == LAST_POS) ? '0 : pos + 1'b1;
      end
      tccw_pkg::OP_LF: begin
        emit     = 1'b1;
        col_next = '0;
        row_next = (row == LAST_ROW) ? '0 : row + 1'b1;
        pos_next = (row == LAST_ROW) ? '0 : pos - CW'(col) + ROW_STEP;
      end
      tccw_pkg::OP_BS: begin
        // home cell: dropped without a result
        if (col != '0 || row != '0) begin
          emit     = 1'b1;
          r_write  = 1'b1;
          r_char   = tccw_pkg::CH_SPACE;
          pos_next = pos - 1'b1;
          r_addr   = pos - 1'b1;
          if (col != '0) begin
            col_next = col - 1'b1;
          end else begin
            col_next = LAST_COL;
            row_next = row - 1'b1;
          end
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= RESET_ROW;
      pos       <= RESET_POS;
      tab_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        col <= col_next;
        row <= row_next;
        pos <= pos_next;
        if (head_cmd.op == tccw_pkg::OP_TAB) begin
          tab_cnt <= done ? '0 : tab_cnt + 1'b1;
        end
      end
      if (fire && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      cell_write      <= r_write;
      cell_address    <= tccw_pkg::POS_W'(r_addr);
      cell_data       <= r_write ? {paper_color, ink_color, r_char} : '0;
      cursor_position <= tccw_pkg::POS_W'(pos_next);
      last            <= r_last;
    end
  end

endmodule

// ===== hw/rtl/text_console_char_writer_core.sv =====
// A byte is written into the command queue, then its first result into the
// output register. Throughput: one byte per cycle for printable, backspace
// and line feed while out_ready is high; a tab holds the back end for
// TAB_SPACES results, one space each. NUL is dropped in the front end and
// yields nothing. Reset (rst, synchronous): queue and output empty, cursor
// at START_ROW, column 0, colors fg 7 / bg 0.
`timescale 1ns / 1ps

module text_console_char_writer_core (
  input  logic                           clk,
  input  logic                           rst,
  // character request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tccw_pkg::CHAR_W-1:0]    char_byte,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           cell_write,
  output logic [tccw_pkg::POS_W-1:0]     cell_address,
  output logic [tccw_pkg::DATA_W-1:0]    cell_data,
  output logic [tccw_pkg::POS_W-1:0]     cursor_position,
  output logic                           last,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [tccw_pkg::COLOR_W-1:0] ink_color;
  logic [tccw_pkg::COLOR_W-1:0] paper_color;
  logic                         q_full;
  logic                         push;
  logic                         pop;
  logic                         head_valid;
  tccw_pkg::cmd_t               push_cmd;
  tccw_pkg::cmd_t               head_cmd;
  logic                         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      ink_color   <= 4'd7;
      paper_color <= 4'd0;
    end else if (psel && penable && pwrite) begin
      if (reg_sel == tccw_pkg::REG_FG) begin
        ink_color <= pwdata[tccw_pkg::COLOR_W-1:0];
      end else begin
        paper_color <= pwdata[tccw_pkg::COLOR_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == tccw_pkg::REG_FG) begin
      prdata[tccw_pkg::COLOR_W-1:0] = ink_color;
    end else begin
      prdata[tccw_pkg::COLOR_W-1:0] = paper_color;
    end
  end

  tccw_front u_front (
    .in_valid  (in_valid),
    .char_byte (char_byte),
    .q_full    (q_full),
    .in_ready  (in_ready),
    .push      (push),
    .cmd       (push_cmd)
  );

  tccw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  tccw_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head_cmd        (head_cmd),
    .ink_color       (ink_color),
    .paper_color     (paper_color),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cell_write      (cell_write),
    .cell_address    (cell_address),
    .cell_data       (cell_data),
    .cursor_position (cursor_position),
    .last            (last)
  );

endmodule

// ===== hw/rtl/tccw_checker.sv =====
// Port-level checks for text_console_char_writer_core, attached by bind.
// Depends on tccw_pkg for field widths.
`timescale 1ns / 1ps

module tccw_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         cell_write,
  input logic [tccw_pkg::POS_W-1:0]   cell_address,
  input logic [tccw_pkg::DATA_W-1:0]  cell_data,
  input logic [tccw_pkg::POS_W-1:0]   cursor_position,
  input logic                         last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_address) &&
      $stable(cell_data) && $stable(cursor_position) && $stable(last))
    else $error("result changed while stalled");

  // no result is pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // line feed result: no write, zero address and data, single result
  a_lf_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cell_write |-> last && cell_address == '0 && cell_data == '0)
    else $error("non-write result malformed");

  // a write leaves the cursor on the cell, one past it, or wrapped home
  a_cursor_near: assert property (@(posedge clk) disable iff (rst)
    out_valid && cell_write |->
      cursor_position == cell_address ||
      cursor_position == tccw_pkg::POS_W'(cell_address + 1'b1) ||
      cursor_position == '0)
    else $error("cursor not next to written cell");

endmodule

bind text_console_char_writer_core tccw_checker u_tccw_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .cell_write      (cell_write),
  .cell_address    (cell_address),
  .cell_data       (cell_data),
  .cursor_position (cursor_position),
  .last            (last)
);
